### design/pfx_pkg.sv
// ----------------------------------------------------------------------------
// Protobuf field extractor package
// Shared types, constants and helper functions of the field extractor.
// ----------------------------------------------------------------------------
package pfx_pkg;

   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = 2;
   localparam int unsigned RSP_CNT_W = 3;

   localparam logic [0:0] CSR_TARGET_TAG = 1'b0;
   localparam logic [0:0] CSR_DEST_SIZE  = 1'b1;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LENGTH  = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      PH_KEY,
      PH_VARINT,
      PH_FIXED,
      PH_LEN,
      PH_PAYLOAD,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic        found;
      logic [2:0]  wire_code;
      logic [63:0] field_value;
      logic [31:0] bytes_consumed;
      logic        last_result;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type item0;
      result_type item1;
   } push_type;

   // Keeps the low 8, 16 or 32 bits for destination sizes 1, 2 and 4.
   function automatic logic [63:0] varint_trunc(input logic [63:0] v,
                                                input logic [31:0] dest);
      logic [63:0] r;
      begin
         case (dest)
            32'd1:   r = {56'd0, v[7:0]};
            32'd2:   r = {48'd0, v[15:0]};
            32'd4:   r = {32'd0, v[31:0]};
            default: r = v;
         endcase
         return r;
      end
   endfunction

endpackage

### design/pfx_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one byte of the encoded message and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface pfx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### design/pfx_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one payload byte or one final search status.
// ----------------------------------------------------------------------------
interface pfx_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic        found;
   logic [2:0]  wire_code;
   logic [63:0] field_value;
   logic [31:0] bytes_consumed;
   logic        last_result;

   modport source (output valid, output kind, output payload_byte, output found,
                   output wire_code, output field_value, output bytes_consumed,
                   output last_result, input ready);
   modport sink (input valid, input kind, input payload_byte, input found,
                 input wire_code, input field_value, input bytes_consumed,
                 input last_result, output ready);
endinterface

### design/pfx_csr_if.sv
// ----------------------------------------------------------------------------
// Register write interface
// Carries a register index and the data to write there.
// ----------------------------------------------------------------------------
interface pfx_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

### design/protobuf_field_by_tag_extractor.sv
// ----------------------------------------------------------------------------
// Protobuf field extractor
// Finds the first field with the target number in a protobuf message and
// reports its payload bytes and final status.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  req_chan  in         data_byte, last_byte: one message byte per transaction
//  rsp_chan  out        payload byte or final status, one item per transaction
//  csr_chan  in         index 0 target_tag, index 1 dest_size
//
// Each request byte is decoded in the cycle it is taken; its results are
// registered into a four-entry result queue that drives the response channel.
// The request side stays ready while at least two queue entries are free, so
// one byte per cycle is sustained while the response side keeps up.
// A stalled response side fills the queue and then holds off requests.
// Synchronous reset clears the search state and both registers to zero.
//
module protobuf_field_by_tag_extractor #(
   parameter int unsigned MAX_VARINT_BYTES = 10
) (
   input  logic      clock,
   input  logic      reset,
   pfx_req_if.sink   req_chan,
   pfx_rsp_if.source rsp_chan,
   pfx_csr_if.sink   csr_chan
);

   pfx_pkg::push_type push;
   logic              room;

   pfx_scan #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .req  (req_chan),
      .csr  (csr_chan),
      .room (room),
      .push (push)
   );

   pfx_rsp_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push (push),
      .room (room),
      .rsp  (rsp_chan)
   );

endmodule

### design/pfx_scan.sv
// ----------------------------------------------------------------------------
// Field scanner
// Walks the wire format one byte per transaction and produces up to two
// result items for each byte.
// ----------------------------------------------------------------------------
module pfx_scan #(
   parameter int unsigned MAX_VARINT_BYTES = 10
) (
   input  logic              clock,
   input  logic              reset,
   pfx_req_if.sink           req,
   pfx_csr_if.sink           csr,
   input  logic              room,
   output pfx_pkg::push_type push
);

   localparam int unsigned CntW = $clog2(MAX_VARINT_BYTES + 1);

   logic [28:0]         target_tag_ff, target_tag_in;
   logic [31:0]         dest_size_ff, dest_size_in;
   pfx_pkg::phase_type  phase_ff, phase_in;
   logic [63:0]         accum_ff, accum_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [2:0]          wt_ff, wt_in;
   logic [31:0]         left_ff, left_in;
   logic [31:0]         copied_ff, copied_in;
   logic [31:0]         offset_ff, offset_in;
   logic                match_ff, match_in;

   logic                accept;
   logic [7:0]          b;
   logic [6:0]          sh;
   logic [63:0]         acc_add;
   logic [CntW-1:0]     cnt_inc;
   logic                v_end, v_over;
   logic [2:0]          fix_idx;
   logic [63:0]         fix_acc;
   logic                ok, fail, emit_pl;
   logic [63:0]         val;
   pfx_pkg::result_type pl_item, st_item;

   assign req.ready = room;
   assign csr.ready = 1'b1;
   assign accept    = req.valid & room;
   assign b         = req.data_byte;

   assign sh      = 7'(cnt_ff) * 7'd7;
   assign acc_add = accum_ff | ({57'd0, b[6:0]} << sh);
   assign cnt_inc = cnt_ff + CntW'(1);
   assign v_end   = ~b[7];
   assign v_over  = b[7] && (cnt_inc >= CntW'(MAX_VARINT_BYTES));

   // Byte position inside a fixed value, counted from the least significant.
   assign fix_idx = ((wt_ff == pfx_pkg::WT_FIXED64) ? 3'd0 : 3'd4) - left_ff[2:0];
   assign fix_acc = accum_ff | ({56'd0, b} << {fix_idx, 3'b000});

   always_comb begin
      target_tag_in = target_tag_ff;
      dest_size_in  = dest_size_ff;
      if (csr.valid) begin
         case (csr.index)
            pfx_pkg::CSR_TARGET_TAG: target_tag_in = csr.wdata[28:0];
            pfx_pkg::CSR_DEST_SIZE:  dest_size_in  = csr.wdata;
            default:                 dest_size_in  = dest_size_ff;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      cnt_in    = cnt_ff;
      wt_in     = wt_ff;
      left_in   = left_ff;
      copied_in = copied_ff;
      offset_in = offset_ff;
      match_in  = match_ff;
      ok        = 1'b0;
      fail      = 1'b0;
      emit_pl   = 1'b0;
      val       = 64'd0;

      if (accept && phase_ff != pfx_pkg::PH_DONE) begin
         offset_in = offset_ff + 32'd1;
         case (phase_ff)
            pfx_pkg::PH_KEY: begin
               accum_in = acc_add;
               cnt_in   = cnt_inc;
               if (v_over) begin
                  fail = 1'b1;
               end else if (v_end) begin
                  wt_in    = acc_add[2:0];
                  match_in = (acc_add[31:3] == target_tag_ff);
                  accum_in = 64'd0;
                  cnt_in   = '0;
                  case (acc_add[2:0])
                     pfx_pkg::WT_VARINT:  phase_in = pfx_pkg::PH_VARINT;
                     pfx_pkg::WT_LENGTH:  phase_in = pfx_pkg::PH_LEN;
                     pfx_pkg::WT_FIXED64: begin
                        phase_in = pfx_pkg::PH_FIXED;
                        left_in  = 32'd8;
                     end
                     pfx_pkg::WT_FIXED32: begin
                        phase_in = pfx_pkg::PH_FIXED;
                        left_in  = 32'd4;
                     end
                     default: fail = 1'b1;
                  endcase
               end
            end
            pfx_pkg::PH_VARINT: begin
               accum_in = acc_add;
               cnt_in   = cnt_inc;
               if (v_over) begin
                  fail = 1'b1;
               end else if (v_end) begin
                  if (match_ff) begin
                     ok  = 1'b1;
                     val = pfx_pkg::varint_trunc(acc_add, dest_size_ff);
                  end else begin
                     phase_in = pfx_pkg::PH_KEY;
                     accum_in = 64'd0;
                     cnt_in   = '0;
                  end
               end
            end
            pfx_pkg::PH_FIXED: begin
               accum_in = fix_acc;
               left_in  = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  if (match_ff) begin
                     ok  = 1'b1;
                     val = fix_acc;
                  end else begin
                     phase_in = pfx_pkg::PH_KEY;
                     accum_in = 64'd0;
                     cnt_in   = '0;
                  end
               end
            end
            pfx_pkg::PH_LEN: begin
               accum_in = acc_add;
               cnt_in   = cnt_inc;
               if (v_over) begin
                  fail = 1'b1;
               end else if (v_end) begin
                  accum_in  = {32'd0, acc_add[31:0]};
                  left_in   = acc_add[31:0];
                  copied_in = 32'd0;
                  if (acc_add[31:0] != 32'd0) begin
                     phase_in = pfx_pkg::PH_PAYLOAD;
                  end else if (match_ff) begin
                     ok = 1'b1;
                  end else begin
                     phase_in = pfx_pkg::PH_KEY;
                     accum_in = 64'd0;
                     cnt_in   = '0;
                  end
               end
            end
            pfx_pkg::PH_PAYLOAD: begin
               if (match_ff && (dest_size_ff == 32'd0 || copied_ff < dest_size_ff)) begin
                  emit_pl   = 1'b1;
                  copied_in = copied_ff + 32'd1;
               end
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  if (match_ff) begin
                     ok  = 1'b1;
                     val = accum_ff;
                  end else begin
                     phase_in = pfx_pkg::PH_KEY;
                     accum_in = 64'd0;
                     cnt_in   = '0;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
         if (ok || fail || req.last_byte) begin
            phase_in = pfx_pkg::PH_DONE;
         end
      end

      // The end of the buffer always restarts the search, keeping registers.
      if (accept && req.last_byte) begin
         phase_in  = pfx_pkg::PH_KEY;
         accum_in  = 64'd0;
         cnt_in    = '0;
         wt_in     = 3'd0;
         left_in   = 32'd0;
         copied_in = 32'd0;
         offset_in = 32'd0;
         match_in  = 1'b0;
      end
   end

   always_comb begin
      pl_item              = '0;
      pl_item.kind         = pfx_pkg::KIND_PAYLOAD;
      pl_item.payload_byte = b;

      st_item             = '0;
      st_item.kind        = pfx_pkg::KIND_STATUS;
      st_item.last_result = 1'b1;
      if (ok) begin
         st_item.found          = 1'b1;
         st_item.wire_code      = wt_ff;
         st_item.field_value    = val;
         st_item.bytes_consumed = offset_ff + 32'd1;
      end

      push       = '0;
      push.item1 = st_item;
      if (accept && phase_ff != pfx_pkg::PH_DONE) begin
         if (emit_pl) begin
            push.item0 = pl_item;
            push.count = (ok || fail || req.last_byte) ? 2'd2 : 2'd1;
         end else begin
            push.item0 = st_item;
            push.count = (ok || fail || req.last_byte) ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_tag_ff <= 29'd0;
         dest_size_ff  <= 32'd0;
         phase_ff      <= pfx_pkg::PH_KEY;
         accum_ff      <= 64'd0;
         cnt_ff        <= '0;
         wt_ff         <= 3'd0;
         left_ff       <= 32'd0;
         copied_ff     <= 32'd0;
         offset_ff     <= 32'd0;
         match_ff      <= 1'b0;
      end else begin
         target_tag_ff <= target_tag_in;
         dest_size_ff  <= dest_size_in;
         phase_ff      <= phase_in;
         accum_ff      <= accum_in;
         cnt_ff        <= cnt_in;
         wt_ff         <= wt_in;
         left_ff       <= left_in;
         copied_ff     <= copied_in;
         offset_ff     <= offset_in;
         match_ff      <= match_in;
      end
   end

endmodule

### design/pfx_rsp_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Holds result items between the scanner and the response channel. Takes up
// to two items per cycle and hands out one when the response side is ready.
// ----------------------------------------------------------------------------
module pfx_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  pfx_pkg::push_type push,
   output logic              room,
   pfx_rsp_if.source         rsp
);

   pfx_pkg::result_type             mem_ff [pfx_pkg::RSP_DEPTH];
   logic [pfx_pkg::RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pfx_pkg::RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pfx_pkg::RSP_CNT_W-1:0]   count_ff, count_in;
   logic [pfx_pkg::RSP_PTR_W-1:0]   wr_next;
   logic                            pop;
   pfx_pkg::result_type             head;

   assign room    = count_ff <= pfx_pkg::RSP_CNT_W'(pfx_pkg::RSP_DEPTH - 2);
   assign pop     = rsp.valid & rsp.ready;
   assign wr_next = wr_ptr_ff + pfx_pkg::RSP_PTR_W'(1);
   assign head    = mem_ff[rd_ptr_ff];

   assign rsp.valid          = count_ff != '0;
   assign rsp.kind           = head.kind;
   assign rsp.payload_byte   = head.payload_byte;
   assign rsp.found          = head.found;
   assign rsp.wire_code      = head.wire_code;
   assign rsp.field_value    = head.field_value;
   assign rsp.bytes_consumed = head.bytes_consumed;
   assign rsp.last_result    = head.last_result;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + pfx_pkg::RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + pfx_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + pfx_pkg::RSP_CNT_W'(push.count)
                  - pfx_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sim/protobuf_field_by_tag_extractor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Protobuf field extractor testbench
// Feeds encoded messages byte by byte, predicts the payload and status
// transactions from its own decoder of the wire format and compares them with
// the response channel while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module protobuf_field_by_tag_extractor_tb;

   localparam int MAX_VARINT_BYTES = 10;
   localparam int PHASE_BYTES = 150;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } msg_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfx_req_if req_if ();
   pfx_rsp_if rsp_if ();
   pfx_csr_if csr_if ();

   protobuf_field_by_tag_extractor #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   always #4 clock = ~clock;

   msg_byte_type        message_bytes[$];
   pfx_pkg::result_type field_results_due[$];
   logic [7:0]          msg_buf[$];
   pfx_pkg::result_type got_item;
   pfx_pkg::result_type due_item;

   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int bad_results = 0;
   logic byte_taken = 1'b0;

   // Decoder state and register copies.
   logic [28:0]        tag_reg;
   logic [31:0]        size_reg;
   pfx_pkg::phase_type ph;
   logic [63:0]        acc;
   int                 vcount;
   logic [31:0]        fnum;
   logic [2:0]         cur_wt;
   logic [31:0]        left;
   logic [31:0]        copied;
   logic [31:0]        offset;
   logic               hit;

   // {last, byte}: hand-built buffers covering each wire type, the payload cap,
   // a zero-length match, an invalid wire type, ignored bytes after a status
   // and a buffer that ends right after a key.
   logic [8:0] directed_bytes [28] = '{
      9'h008, 9'h0FF, 9'h07F, 9'h155,
      9'h00A, 9'h003, 9'h000, 9'h0FF, 9'h1A5,
      9'h00A, 9'h100,
      9'h00D, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
      9'h009, 9'h001, 9'h002, 9'h004, 9'h008, 9'h010, 9'h020, 9'h040, 9'h180,
      9'h013, 9'h100,
      9'h108
   };

   function automatic pfx_pkg::result_type pack_result(input logic kind, input logic [7:0] pb,
                                                       input logic fnd, input logic [2:0] wt,
                                                       input logic [63:0] val,
                                                       input logic [31:0] cons);
      pfx_pkg::result_type r;
      r.kind = kind;
      r.payload_byte = pb;
      r.found = fnd;
      r.wire_code = wt;
      r.field_value = val;
      r.bytes_consumed = cons;
      r.last_result = (kind == pfx_pkg::KIND_STATUS);
      return r;
   endfunction

   function automatic void next_key();
      ph = pfx_pkg::PH_KEY;
      acc = 64'd0;
      vcount = 0;
   endfunction

   function automatic void restart_search();
      next_key();
      fnum = 32'd0;
      cur_wt = 3'd0;
      left = 32'd0;
      copied = 32'd0;
      offset = 32'd0;
      hit = 1'b0;
   endfunction

   // Returns 1 when the varint ends, 0 when more bytes follow, -1 when overlong.
   function automatic int varint_step(input logic [7:0] b);
      if (vcount < 10) acc = acc | ({57'd0, b[6:0]} << (7 * vcount));
      vcount = vcount + 1;
      if (!b[7]) return 1;
      if (vcount >= MAX_VARINT_BYTES) return -1;
      return 0;
   endfunction

   task automatic scan_byte(input logic [7:0] b, input logic last);
      int r;
      int idx;
      logic fail;
      logic done_ok;
      logic [63:0] val;
      logic [63:0] keep;
      logic [31:0] key;
      fail = 1'b0;
      done_ok = 1'b0;
      val = 64'd0;
      if (ph == pfx_pkg::PH_DONE) begin
         if (last) restart_search();
      end else begin
         offset = offset + 32'd1;
         case (ph)
            pfx_pkg::PH_KEY: begin
               r = varint_step(b);
               if (r < 0) begin
                  fail = 1'b1;
               end else if (r > 0) begin
                  key = acc[31:0];
                  cur_wt = key[2:0];
                  fnum = key >> 3;
                  hit = (fnum == {3'b000, tag_reg});
                  acc = 64'd0;
                  vcount = 0;
                  case (cur_wt)
                     pfx_pkg::WT_VARINT: ph = pfx_pkg::PH_VARINT;
                     pfx_pkg::WT_LENGTH: ph = pfx_pkg::PH_LEN;
                     pfx_pkg::WT_FIXED64: begin
                        ph = pfx_pkg::PH_FIXED;
                        left = 32'd8;
                     end
                     pfx_pkg::WT_FIXED32: begin
                        ph = pfx_pkg::PH_FIXED;
                        left = 32'd4;
                     end
                     default: fail = 1'b1;
                  endcase
               end
            end
            pfx_pkg::PH_VARINT: begin
               r = varint_step(b);
               if (r < 0) begin
                  fail = 1'b1;
               end else if (r > 0) begin
                  if (hit) begin
                     case (size_reg)
                        32'd1:   keep = 64'h0000_0000_0000_00FF;
                        32'd2:   keep = 64'h0000_0000_0000_FFFF;
                        32'd4:   keep = 64'h0000_0000_FFFF_FFFF;
                        default: keep = '1;
                     endcase
                     done_ok = 1'b1;
                     val = acc & keep;
                  end else begin
                     next_key();
                  end
               end
            end
            pfx_pkg::PH_FIXED: begin
               idx = ((cur_wt == pfx_pkg::WT_FIXED64) ? 8 : 4) - int'(left);
               acc = acc | ({56'd0, b} << (8 * (idx & 7)));
               left = left - 32'd1;
               if (left == 32'd0) begin
                  if (hit) begin
                     done_ok = 1'b1;
                     val = acc;
                  end else begin
                     next_key();
                  end
               end
            end
            pfx_pkg::PH_LEN: begin
               r = varint_step(b);
               if (r < 0) begin
                  fail = 1'b1;
               end else if (r > 0) begin
                  acc[63:32] = 32'd0;
                  left = acc[31:0];
                  copied = 32'd0;
                  if (left != 32'd0) ph = pfx_pkg::PH_PAYLOAD;
                  else if (hit) done_ok = 1'b1;
                  else next_key();
               end
            end
            default: begin
               if (hit && (size_reg == 32'd0 || copied < size_reg)) begin
                  field_results_due.push_back(pack_result(pfx_pkg::KIND_PAYLOAD, b, 1'b0,
                                                          3'd0, 64'd0, 32'd0));
                  copied = copied + 32'd1;
               end
               left = left - 32'd1;
               if (left == 32'd0) begin
                  if (hit) begin
                     done_ok = 1'b1;
                     val = acc;
                  end else begin
                     next_key();
                  end
               end
            end
         endcase
         if (done_ok) begin
            field_results_due.push_back(pack_result(pfx_pkg::KIND_STATUS, 8'd0, 1'b1,
                                                    cur_wt, val, offset));
            ph = pfx_pkg::PH_DONE;
         end else if (fail || last) begin
            field_results_due.push_back(pack_result(pfx_pkg::KIND_STATUS, 8'd0, 1'b0,
                                                    3'd0, 64'd0, 32'd0));
            ph = pfx_pkg::PH_DONE;
         end
         if (last) restart_search();
      end
   endtask

   task automatic show_result(input string label, input pfx_pkg::result_type r);
      $display("   %s kind=%0d byte=%02h found=%0d wire_code=%0d value=%016h",
               label, r.kind, r.payload_byte, r.found, r.wire_code, r.field_value);
      $display("      consumed=%0d last=%0d", r.bytes_consumed, r.last_result);
   endtask

   // Request acceptance feeds the decoder, response acceptance is checked.
   always @(posedge clock) begin
      byte_taken = 1'b0;
      if (reset) begin
         tag_reg = 29'd0;
         size_reg = 32'd0;
         restart_search();
      end else begin
         if (req_if.valid && req_if.ready) begin
            byte_taken = 1'b1;
            scan_byte(req_if.data_byte, req_if.last_byte);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got_item.kind = rsp_if.kind;
            got_item.payload_byte = rsp_if.payload_byte;
            got_item.found = rsp_if.found;
            got_item.wire_code = rsp_if.wire_code;
            got_item.field_value = rsp_if.field_value;
            got_item.bytes_consumed = rsp_if.bytes_consumed;
            got_item.last_result = rsp_if.last_result;
            if (field_results_due.size() == 0) begin
               bad_results = bad_results + 1;
               if (bad_results <= 10) begin
                  $display("%0t: unexpected response transaction", $realtime);
                  show_result("actual  ", got_item);
               end
            end else begin
               due_item = field_results_due.pop_front();
               if (got_item.kind !== due_item.kind ||
                   got_item.payload_byte !== due_item.payload_byte ||
                   got_item.found !== due_item.found ||
                   got_item.wire_code !== due_item.wire_code ||
                   got_item.field_value !== due_item.field_value ||
                   got_item.bytes_consumed !== due_item.bytes_consumed ||
                   got_item.last_result !== due_item.last_result) begin
                  bad_results = bad_results + 1;
                  if (bad_results <= 10) begin
                     $display("%0t: wrong response transaction", $realtime);
                     show_result("expected", due_item);
                     show_result("actual  ", got_item);
                  end
               end
            end
         end
      end
   end

   // Request driver: a new byte goes out only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || byte_taken) begin
         if (message_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.data_byte <= message_bytes[0].data;
            req_if.last_byte <= message_bytes[0].last;
            void'(message_bytes.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == pfx_pkg::CSR_TARGET_TAG) tag_reg = data[28:0];
      else size_reg = data;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (message_bytes.size() != 0 || req_if.valid || field_results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_uint(input logic [63:0] v, input int pad);
      logic [7:0] b;
      int i;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 64'd0 || pad > 0) b[7] = 1'b1;
         msg_buf.push_back(b);
      end while (v != 64'd0);
      for (i = 1; i <= pad; i++) msg_buf.push_back((i == pad) ? 8'h00 : 8'h80);
   endtask

   // Random varint content of n bytes; an overlong one keeps every continuation bit.
   task automatic put_raw_varint(input int n, input logic overlong);
      logic [7:0] b;
      int i;
      for (i = 0; i < n; i++) begin
         b = 8'($urandom_range(0, 255));
         b[7] = (i < n - 1) || overlong;
         msg_buf.push_back(b);
      end
   endtask

   task automatic put_random_bytes(input int n);
      int i;
      for (i = 0; i < n; i++) msg_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic put_key(input logic [28:0] fn, input logic [2:0] wt);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) put_uint({32'($urandom), fn, wt}, 0);
      else if (pick < 20) put_uint({32'd0, fn, wt}, $urandom_range(1, 5));
      else put_uint({32'd0, fn, wt}, 0);
   endtask

   function automatic logic [28:0] choose_fn();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return tag_reg;
      if (pick < 70) return 29'($urandom_range(0, 20));
      if (pick < 85) return $urandom_range(0, 1) ? tag_reg + 29'd1 : tag_reg - 29'd1;
      return 29'($urandom);
   endfunction

   task automatic put_field(input logic [28:0] fn);
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         put_key(fn, pfx_pkg::WT_VARINT);
         if ($urandom_range(0, 99) < 70) begin
            put_raw_varint($urandom_range(1, 10), 1'b0);
         end else begin
            case ($urandom_range(0, 5))
               0: put_uint(64'd0, 0);
               1: put_uint('1, 0);
               2: put_uint(64'hFF, 0);
               3: put_uint(64'hFFFF, 0);
               4: put_uint(64'hFFFF_FFFF, 0);
               default: put_uint(64'h8000_0000_0000_0000, 0);
            endcase
         end
      end else if (pick < 60) begin
         put_key(fn, pfx_pkg::WT_LENGTH);
         pick = $urandom_range(0, 99);
         if (pick < 15) len = 0;
         else if (pick < 85) len = $urandom_range(1, 8);
         else len = $urandom_range(9, 40);
         put_uint(64'(len), ($urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : 0);
         put_random_bytes(len);
      end else if (pick < 80) begin
         put_key(fn, pfx_pkg::WT_FIXED64);
         put_random_bytes(8);
      end else begin
         put_key(fn, pfx_pkg::WT_FIXED32);
         put_random_bytes(4);
      end
   endtask

   task automatic gen_message();
      int style;
      int nf;
      int i;
      int x;
      msg_buf.delete();
      style = $urandom_range(0, 99);
      if (style < 70) begin
         nf = $urandom_range(1, 4);
         for (i = 0; i < nf; i++) put_field(choose_fn());
      end else if (style < 88) begin
         nf = $urandom_range(0, 2);
         for (i = 0; i < nf; i++) put_field(choose_fn());
         case ($urandom_range(0, 5))
            0: put_raw_varint(10, 1'b1);
            1: begin
               put_key(choose_fn(), pfx_pkg::WT_VARINT);
               put_raw_varint(10, 1'b1);
            end
            2: begin
               put_key(choose_fn(), pfx_pkg::WT_LENGTH);
               put_raw_varint(10, 1'b1);
            end
            3: begin
               x = $urandom_range(0, 3);
               put_key(choose_fn(), 3'((x < 2) ? 3 + x : 4 + x));
            end
            4: begin
               // The buffer is cut at a random byte, which may fall inside a field.
               put_field(choose_fn());
               x = $urandom_range(1, msg_buf.size());
               while (msg_buf.size() > x) void'(msg_buf.pop_back());
            end
            default: begin
               put_key(choose_fn(), pfx_pkg::WT_LENGTH);
               put_raw_varint($urandom_range(5, 10), 1'b0);
               put_random_bytes($urandom_range(0, 6));
            end
         endcase
         put_random_bytes($urandom_range(0, 3));
      end else begin
         put_random_bytes($urandom_range(1, 12));
      end
      if (msg_buf.size() == 0) put_random_bytes(1);
      for (i = 0; i < msg_buf.size(); i++)
         message_bytes.push_back({(i == msg_buf.size() - 1), msg_buf[i]});
   endtask

   task automatic run_phase(input logic [31:0] tag, input logic [31:0] dest,
                            input int idle, input int stall);
      int queued;
      sender_idle_pct = idle;
      rsp_stall_pct = stall;
      write_reg(pfx_pkg::CSR_TARGET_TAG, tag);
      write_reg(pfx_pkg::CSR_DEST_SIZE, dest);
      queued = 0;
      while (queued < PHASE_BYTES) begin
         gen_message();
         queued = queued + msg_buf.size();
      end
      wait_drained();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data_byte = 8'd0;
      req_if.last_byte = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = pfx_pkg::CSR_TARGET_TAG;
      csr_if.wdata = 32'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(pfx_pkg::CSR_TARGET_TAG, 32'd1);
      write_reg(pfx_pkg::CSR_DEST_SIZE, 32'd2);
      for (int i = 0; i < 28; i++)
         message_bytes.push_back({directed_bytes[i][8], directed_bytes[i][7:0]});
      wait_drained();

      run_phase(32'd1, 32'd0, 0, 0);
      run_phase(32'h1FFF_FFFF, 32'hFFFF_FFFF, 56, 0);
      run_phase(32'd0, 32'd1, 0, 56);
      run_phase(32'd15, 32'd4, 6, 6);
      run_phase(32'd16, 32'd8, 0, 0);
      // Bits above the 29-bit field number are written too.
      run_phase($urandom, 32'd3, 56, 0);
      run_phase($urandom & 32'h0000_00FF, $urandom, 0, 56);
      run_phase(32'd2, 32'd5, 6, 6);

      if (bad_results == 0) begin
         $display("protobuf_field_by_tag_extractor: match");
      end else begin
         $display("protobuf_field_by_tag_extractor: mismatch");
      end
      $finish;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("protobuf_field_by_tag_extractor: mismatch");
      $finish;
   end

endmodule
